>>> design/rse_pkg.sv
// ----------------------------------------------------------------------------
// rse_pkg: shared types and constants
// Command and status codes, stack and queue sizing, the front-to-back token type and the engine states.
// ----------------------------------------------------------------------------
package rse_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int PTR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

   typedef enum logic [2:0] {
      CMD_PUSH    = 3'd0,
      CMD_ADD     = 3'd1,
      CMD_SUB     = 3'd2,
      CMD_MUL     = 3'd3,
      CMD_DIV     = 3'd4,
      CMD_REPORT  = 3'd5,
      CMD_INVALID = 3'd6,
      CMD_UNUSED  = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_UNDERFLOW = 3'd1,
      ST_OVERFLOW  = 3'd2,
      ST_DIVZERO   = 3'd3,
      ST_INVALID   = 3'd4
   } status_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] operand_value;
   } token_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EXEC,
      S_DIV,
      S_WRITE,
      S_EMIT,
      S_HALT
   } state_type;

endpackage

>>> design/rse_front.sv
// ----------------------------------------------------------------------------
// rse_front: token intake
// Accepts request beats into a small queue; classifies invalid codes so the
// front stops accepting after one reaches the queue.
// ----------------------------------------------------------------------------
module rse_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_command,
   input  logic signed [31:0]  req_operand_value,
   output logic                tok_valid,
   input  logic                tok_ready,
   output rse_pkg::token_type  tok
);
   rse_pkg::token_type mem_ff [rse_pkg::FIFO_DEPTH];
   logic [rse_pkg::FIFO_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [rse_pkg::FIFO_PTR_W:0] cnt_ff, cnt_in;
   logic stop_ff, stop_in;
   logic push, pop, bad;

   assign bad = (req_command == rse_pkg::CMD_INVALID) || (req_command == rse_pkg::CMD_UNUSED);
   assign req_ready = !stop_ff && (cnt_ff != (rse_pkg::FIFO_PTR_W+1)'(rse_pkg::FIFO_DEPTH));
   assign push = req_valid && req_ready;
   assign tok_valid = cnt_ff != '0;
   assign pop = tok_valid && tok_ready;
   assign tok = mem_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (rse_pkg::FIFO_PTR_W+1)'(push) - (rse_pkg::FIFO_PTR_W+1)'(pop);
      stop_in = stop_ff || (push && bad);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
         stop_ff <= 1'b0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
         stop_ff <= stop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= '{command: req_command, operand_value: req_operand_value};
   end
endmodule

>>> design/rse_divider.sv
// ----------------------------------------------------------------------------
// rse_divider: iterative Q16.16 divider
// Restoring division of |left|<<16 by |right|, one quotient bit per cycle,
// then sign fix and saturation.
// ----------------------------------------------------------------------------
module rse_divider (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [31:0]  left,
   input  logic [31:0]  right,
   output logic         done,
   output logic [31:0]  quotient
);
   logic [47:0] num_ff, num_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic        neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] q_ff, q_in;
   logic [32:0] trial;
   logic [31:0] al, ar;
   logic [48:0] sq;

   assign al = left[31] ? (~left + 1'b1) : left;
   assign ar = right[31] ? (~right + 1'b1) : right;
   assign trial = {rem_ff[31:0], num_ff[47]};
   assign done = done_ff;
   assign quotient = q_ff;

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      q_in = q_ff;
      done_in = 1'b0;
      sq = '0;
      if (start) begin
         num_in = {al, 16'd0};
         rem_in = '0;
         den_in = ar;
         neg_in = left[31] ^ right[31];
         busy_in = 1'b1;
         cnt_in = 6'd48;
      end else if (busy_ff) begin
         if (cnt_ff != 6'd0) begin
            if (trial >= {1'b0, den_ff}) begin
               rem_in = trial - {1'b0, den_ff};
               num_in = {num_ff[46:0], 1'b1};
            end else begin
               rem_in = trial;
               num_in = {num_ff[46:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
         end else begin
            sq = neg_ff ? (~{1'b0, num_ff} + 1'b1) : {1'b0, num_ff};
            if (!sq[48] && sq[47:31] != '0) q_in = 32'h7FFF_FFFF;
            else if (sq[48] && sq[47:31] != 17'h1FFFF) q_in = 32'h8000_0000;
            else q_in = sq[31:0];
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      q_ff <= q_in;
   end
endmodule

>>> design/rse_back.sv
// ----------------------------------------------------------------------------
// rse_back: stack engine
// Pops tokens from the queue, reads operands from the stack memory, runs the
// arithmetic and drives the response register.
// ----------------------------------------------------------------------------
module rse_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                tok_valid,
   output logic                tok_ready,
   input  rse_pkg::token_type  tok,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_result_value,
   output logic [2:0]          rsp_status
);
   logic [31:0] stack_mem [rse_pkg::STACK_DEPTH];
   rse_pkg::state_type state_ff, state_in;
   logic [rse_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   rse_pkg::token_type t_ff;
   logic [31:0] ra_ff, rb_ff, res_ff, res_in, val_ff, val_in;
   logic [2:0]  st_ff, st_in;
   logic [63:0] prod_ff;
   logic        mul_ff;
   logic [rse_pkg::PTR_W-1:0] rda, rdb, wa;
   logic        wr_en, div_start, div_done;
   logic [31:0] div_q;
   logic [32:0] sum;
   logic [63:0] p;
   logic [47:0] ps;
   logic signed [32:0] lsum, rsum;

   rse_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .left(rb_ff), .right(ra_ff), .done(div_done), .quotient(div_q)
   );

   assign tok_ready = (state_ff == rse_pkg::S_IDLE);
   assign rda = rse_pkg::PTR_W'(cnt_ff - 1'b1);
   assign rdb = rse_pkg::PTR_W'(cnt_ff - 2'd2);
   assign rsp_result_value = val_ff;
   assign rsp_status = st_ff;
   assign rsp_valid = (state_ff == rse_pkg::S_EMIT);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rse_pkg::S_IDLE: if (tok_valid) state_in = rse_pkg::S_READ;
         rse_pkg::S_READ: state_in = rse_pkg::S_EXEC;
         rse_pkg::S_EXEC: begin
            case (t_ff.command)
               rse_pkg::CMD_PUSH:
                  state_in = (cnt_ff == rse_pkg::CNT_W'(rse_pkg::STACK_DEPTH)) ?
                     rse_pkg::S_EMIT : rse_pkg::S_IDLE;
               rse_pkg::CMD_REPORT: state_in = rse_pkg::S_EMIT;
               rse_pkg::CMD_ADD, rse_pkg::CMD_SUB, rse_pkg::CMD_MUL:
                  state_in = (cnt_ff < 2) ? rse_pkg::S_EMIT : rse_pkg::S_WRITE;
               rse_pkg::CMD_DIV:
                  state_in = (cnt_ff < 2) ? rse_pkg::S_EMIT :
                     (ra_ff == '0) ? rse_pkg::S_WRITE : rse_pkg::S_DIV;
               default: state_in = rse_pkg::S_EMIT;
            endcase
         end
         rse_pkg::S_DIV: if (div_done) state_in = rse_pkg::S_WRITE;
         rse_pkg::S_WRITE: state_in = (st_ff == rse_pkg::ST_DIVZERO) ?
            rse_pkg::S_EMIT : rse_pkg::S_IDLE;
         rse_pkg::S_EMIT: if (rsp_ready)
            state_in = (st_ff == rse_pkg::ST_INVALID) ? rse_pkg::S_HALT : rse_pkg::S_IDLE;
         rse_pkg::S_HALT: state_in = rse_pkg::S_HALT;
         default: state_in = rse_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      res_in = res_ff;
      val_in = val_ff;
      st_in = st_ff;
      wr_en = 1'b0;
      wa = rdb;
      div_start = 1'b0;
      lsum = $signed({rb_ff[31], rb_ff});
      rsum = $signed({ra_ff[31], ra_ff});
      sum = '0;
      ps = prod_ff[63:16];
      case (state_ff)
         rse_pkg::S_EXEC: begin
            val_in = '0;
            st_in = rse_pkg::ST_OK;
            case (t_ff.command)
               rse_pkg::CMD_PUSH:
                  if (cnt_ff == rse_pkg::CNT_W'(rse_pkg::STACK_DEPTH))
                     st_in = rse_pkg::ST_OVERFLOW;
                  else begin
                     wr_en = 1'b1;
                     wa = rse_pkg::PTR_W'(cnt_ff);
                     cnt_in = cnt_ff + 1'b1;
                  end
               rse_pkg::CMD_REPORT:
                  if (cnt_ff == '0) st_in = rse_pkg::ST_UNDERFLOW;
                  else begin
                     val_in = ra_ff;
                     cnt_in = cnt_ff - 1'b1;
                  end
               rse_pkg::CMD_ADD, rse_pkg::CMD_SUB, rse_pkg::CMD_MUL, rse_pkg::CMD_DIV:
                  if (cnt_ff < 2) st_in = rse_pkg::ST_UNDERFLOW;
                  else begin
                     if (t_ff.command == rse_pkg::CMD_SUB) sum = 33'(lsum - rsum);
                     else sum = 33'(lsum + rsum);
                     if (sum[32] != sum[31])
                        res_in = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                     else res_in = sum[31:0];
                     if (t_ff.command == rse_pkg::CMD_DIV) begin
                        if (ra_ff == '0) begin
                           st_in = rse_pkg::ST_DIVZERO;
                           res_in = rb_ff[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                        end else div_start = 1'b1;
                     end
                  end
               default: st_in = rse_pkg::ST_INVALID;
            endcase
         end
         rse_pkg::S_DIV: if (div_done) res_in = div_q;
         rse_pkg::S_WRITE: begin
            wr_en = 1'b1;
            wa = rdb;
            cnt_in = cnt_ff - 1'b1;
            if (mul_ff) begin
               if (!ps[47] && ps[46:31] != '0) res_in = 32'h7FFF_FFFF;
               else if (ps[47] && ps[46:31] != 16'hFFFF) res_in = 32'h8000_0000;
               else res_in = ps[31:0];
            end
         end
         default: ;
      endcase
   end

   assign p = 64'($signed(rb_ff) * $signed(ra_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rse_pkg::S_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
      if (state_ff == rse_pkg::S_IDLE) t_ff <= tok;
      if (state_ff == rse_pkg::S_READ) begin
         ra_ff <= stack_mem[rda];
         rb_ff <= stack_mem[rdb];
      end
      if (state_ff == rse_pkg::S_EXEC) begin
         prod_ff <= p;
         mul_ff <= (t_ff.command == rse_pkg::CMD_MUL);
      end
      res_ff <= res_in;
      val_ff <= val_in;
      st_ff <= st_in;
      if (wr_en) stack_mem[wa] <= (state_ff == rse_pkg::S_EXEC) ? t_ff.operand_value :
         (mul_ff ? res_in : res_ff);
   end
endmodule

>>> design/rpn_stack_evaluator.sv
// ----------------------------------------------------------------------------
// rpn_stack_evaluator: reverse Polish evaluator, signed Q16.16
// Decoded tokens in, report and error beats out.
// ----------------------------------------------------------------------------
// Request channel: req_valid/req_ready with req_command, req_operand_value.
// Response channel: rsp_valid/rsp_ready with rsp_result_value, rsp_status.
// A front queue of four tokens takes request beats while the stack engine
// works; each token goes through read and execute, then a stack write for
// add, subtract and multiply, and for divide the iterative divider (one
// quotient bit per cycle over 48 bits) and the write; beats wait in emit.
// A response beat holds in its register until taken; while the receiver
// stalls, the engine waits and the queue keeps filling up to its depth.
// After an invalid command is queued, no more request beats are taken, and
// after its status beat the block stays halted until reset.
// Synchronous reset empties the queue and stack and clears the halt.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_command,
   input  logic signed [31:0]  req_operand_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_result_value,
   output logic [2:0]          rsp_status
);
   logic tok_valid, tok_ready;
   rse_pkg::token_type tok;

   rse_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_operand_value(req_operand_value),
      .tok_valid(tok_valid), .tok_ready(tok_ready), .tok(tok)
   );

   rse_back u_back (
      .clock(clock), .reset(reset), .tok_valid(tok_valid), .tok_ready(tok_ready),
      .tok(tok), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_value(rsp_result_value), .rsp_status(rsp_status)
   );

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != rse_pkg::ST_OK |-> rsp_result_value == '0)
      else $error("error beat with nonzero value");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped while stalled");

   a_halt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_status == rse_pkg::ST_INVALID |=> !req_ready)
      else $error("requests taken after halt");
endmodule
